@@ rtl/dnd_pkg.sv @@
// Shared constants, status codes and the byte-push request type for the DNS name decompressor.
// No dependencies; the top level and the chunk packer import it.
package dnd_pkg;

  // Packet memory geometry and walk limits
  localparam int PKT_MAX     = 512;
  localparam int ADDR_W      = $clog2(PKT_MAX);
  localparam int DEPTH_LIMIT = 10;
  localparam int JMP_W       = $clog2(DEPTH_LIMIT + 1);
  // Walk pointer: a pointer target (up to packet_len) plus the span one level can read
  localparam int PTR_W       = 12;

  // Name buffer and chunking
  localparam int NAME_MAX    = 256;
  localparam int ROOM_MIN    = 3;
  localparam int CHUNK_BYTES = 8;

  // Stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 96;

  // Item kinds carried on in_tuser
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // Walk status codes
  localparam logic [2:0] ST_END       = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BAD_AFTER = 3'd2;
  localparam logic [2:0] ST_BAD_FIRST = 3'd3;
  localparam logic [2:0] ST_DEPTH     = 3'd4;

  // Label byte decoding
  localparam logic [1:0] PTR_TAG    = 2'b11;
  localparam logic [7:0] DOT_CHAR   = 8'h2e;
  localparam logic [9:0] OFFSET_SAT = 10'd1023;

  // One request from the walker to the chunk packer
  typedef struct packed {
    logic       put;          // append data to the current chunk
    logic [7:0] data;
    logic       fin;          // close the decode with the last chunk
    logic [2:0] status;
    logic [8:0] name_len;
    logic [9:0] next_offset;
  } dnd_push_t;

endpackage

@@ rtl/dnd_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module dnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/dnd_chunker.sv @@
// Chunk packer: gathers name bytes into eight-byte chunks and holds the output register.
// Depends on dnd_pkg.
module dnd_chunker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dnd_pkg::dnd_push_t              req,
  output logic                            ack,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] chars, [67:64] valid_bytes, [70:68] status, [79:71] name_len,
  // [89:80] next_offset, [95:90] zero
  output logic [dnd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import dnd_pkg::*;

  logic [63:0]            chunk_r, chunk_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic                   olast_r, olast_nxt;
  logic                   slot_free;
  logic                   chunk_full;

  assign slot_free  = !ovalid_r || out_tready;
  assign chunk_full = (cnt_r == 4'(CHUNK_BYTES));

  // Stall the walker when a chunk must leave but the output register is still held
  assign ack = !(((req.put && chunk_full) || req.fin) && !slot_free);

  always_comb begin
    chunk_nxt  = chunk_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    if (req.fin) begin
      // Close the decode: send what is gathered with the summary fields
      if (slot_free) begin
        ovalid_nxt = 1'b1;
        olast_nxt  = 1'b1;
        odata_nxt  = OUT_TDATA_W'({req.next_offset, req.name_len, req.status, cnt_r, chunk_r});
        chunk_nxt  = '0;
        cnt_nxt    = '0;
      end
    end else if (req.put) begin
      if (chunk_full) begin
        // Send the full chunk and start the next one with this byte
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b0;
          odata_nxt  = OUT_TDATA_W'({cnt_r, chunk_r});
          chunk_nxt  = 64'(req.data);
          cnt_nxt    = 4'd1;
        end
      end else begin
        chunk_nxt = chunk_r | (64'(req.data) << {cnt_r[2:0], 3'b000});
        cnt_nxt   = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r  <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      chunk_r  <= chunk_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

@@ rtl/dns_name_decompressor.sv @@
// DNS name decompressor top level: packet memory, label walker and configuration register.
// Depends on dnd_pkg, dnd_ram and dnd_chunker.
//
// Load items (in_tuser 0) write one packet byte each. A decode item
// (in_tuser 1) walks the labels from start_offset, following compression pointers, and
// returns the dotted name with its zero terminator in chunks of eight bytes; the last
// chunk carries the status, the name length and the offset after the name. A bad first
// pointer or the depth limit closes the decode with no terminator. The walk reads one
// packet byte per cycle while the output is not held, through the single read port of
// the packet memory (registered read, next address chosen from the byte just read), and
// passes through a separator state per label, then a terminator state and a close state.
// No new item is taken until the decode has handed its last chunk to the output register.
// name_space may be written at any idle time and applies from the next decode.
module dns_name_decompressor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [8:0] byte_addr, [16:9] byte_value, [26:17] packet_len, [35:27] start_offset,
  // [39:36] zero
  input  logic [dnd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] chars, [67:64] valid_bytes, [70:68] status, [79:71] name_len,
  // [89:80] next_offset, [95:90] zero
  output logic [dnd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // last
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [8:0]                      cfg_data
);
  import dnd_pkg::*;

  // Walker states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_LAB  = 3'd2;
  localparam logic [2:0] S_DOT  = 3'd3;
  localparam logic [2:0] S_PTR  = 3'd4;
  localparam logic [2:0] S_TERM = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // Input fields
  logic [8:0] byte_addr;
  logic [7:0] byte_value;
  logic [9:0] packet_len;
  logic [8:0] start_offset;
  logic       in_xfer;

  // Configuration
  logic [8:0] name_space_r;
  logic [8:0] room_init;

  // Walker registers
  logic [2:0]       state_r, state_nxt;
  logic [PTR_W-1:0] s_r, s_nxt;
  logic [8:0]       pos_r, pos_nxt;
  logic [8:0]       lvl_r, lvl_nxt;
  logic [8:0]       room_r, room_nxt;
  logic [9:0]       limit_r, limit_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [5:0]       hi_r, hi_nxt;
  logic [JMP_W-1:0] jumps_r, jumps_nxt;
  logic [9:0]       resume_r, resume_nxt;
  logic [2:0]       status_r, status_nxt;

  // Memory and datapath
  logic             mem_we;
  logic [PTR_W-1:0] load_addr;
  logic [PTR_W-1:0] rd_ptr;
  logic [7:0]       mem_q;
  logic [7:0]       cur_byte;
  logic [PTR_W:0]   s_p1;
  logic [9:0]       resume_here;
  logic             full1;
  logic             full2;
  logic [13:0]      ptr_off;
  logic             ptr_bad;
  logic [JMP_W-1:0] jumps_p1;
  dnd_push_t        push;
  logic             push_ack;

  assign byte_addr    = in_tdata[8:0];
  assign byte_value   = in_tdata[16:9];
  assign packet_len   = in_tdata[26:17];
  assign start_offset = in_tdata[35:27];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Hold the name space register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_space_r <= 9'(NAME_MAX);
    end else if (cfg_valid && cfg_ready) begin
      name_space_r <= cfg_data;
    end
  end

  // Clamp the name space to the usable range
  always_comb begin
    if (name_space_r < 9'(ROOM_MIN)) begin
      room_init = 9'(ROOM_MIN);
    end else if (name_space_r > 9'(NAME_MAX)) begin
      room_init = 9'(NAME_MAX);
    end else begin
      room_init = name_space_r;
    end
  end

  // Packet memory: loads write, the walker reads the byte it will need next cycle
  assign load_addr = PTR_W'(byte_addr);
  assign mem_we    = in_xfer && (in_tuser == FUNC_LOAD) && (load_addr < PTR_W'(PKT_MAX));
  assign rd_ptr    = (state_r == S_IDLE) ? PTR_W'(start_offset) : s_nxt;

  dnd_ram #(
    .WIDTH (8),
    .DEPTH (PKT_MAX)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (load_addr[ADDR_W-1:0]),
    .wdata (byte_value),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (mem_q)
  );

  // Bytes beyond the packet or the memory read as zero
  assign cur_byte = ((s_r >= PTR_W'(limit_r)) || (s_r >= PTR_W'(PKT_MAX))) ? 8'h00 : mem_q;

  assign s_p1        = {1'b0, s_r} + (PTR_W+1)'(1);
  assign resume_here = (s_p1 > (PTR_W+1)'(OFFSET_SAT)) ? OFFSET_SAT : s_p1[9:0];
  assign full1       = ({1'b0, pos_r} + 10'd1) >= {1'b0, room_r};
  assign full2       = ({1'b0, pos_r} + 10'd2) >= {1'b0, room_r};
  assign ptr_off     = {hi_r, cur_byte};
  assign ptr_bad     = ptr_off > 14'(limit_r);
  assign jumps_p1    = jumps_r + JMP_W'(1);

  // Label walker
  always_comb begin
    state_nxt  = state_r;
    s_nxt      = s_r;
    pos_nxt    = pos_r;
    lvl_nxt    = lvl_r;
    room_nxt   = room_r;
    limit_nxt  = limit_r;
    cnt_nxt    = cnt_r;
    hi_nxt     = hi_r;
    jumps_nxt  = jumps_r;
    resume_nxt = resume_r;
    status_nxt = status_r;
    push             = '0;
    push.status      = status_r;
    push.name_len    = pos_r;
    push.next_offset = resume_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_tuser == FUNC_DECODE)) begin
          room_nxt   = room_init;
          limit_nxt  = packet_len;
          s_nxt      = PTR_W'(start_offset);
          pos_nxt    = '0;
          lvl_nxt    = '0;
          jumps_nxt  = '0;
          resume_nxt = 10'(start_offset);
          status_nxt = ST_END;
          state_nxt  = S_LEN;
        end
      end
      S_LEN: begin
        // Classify the length byte: end, out of room, pointer or label
        if (cur_byte == 8'h00) begin
          status_nxt = ST_END;
          if (jumps_r == '0) resume_nxt = resume_here;
          state_nxt = S_TERM;
        end else if (full2) begin
          status_nxt = ST_FULL;
          if (jumps_r == '0) resume_nxt = resume_here;
          state_nxt = S_TERM;
        end else if (cur_byte[7:6] == PTR_TAG) begin
          hi_nxt    = cur_byte[5:0];
          s_nxt     = s_p1[PTR_W-1:0];
          state_nxt = S_PTR;
        end else begin
          cnt_nxt   = cur_byte;
          s_nxt     = s_p1[PTR_W-1:0];
          state_nxt = S_LAB;
        end
      end
      S_LAB: begin
        // Copy label bytes while room remains
        if ((cnt_r != 8'd0) && !full1) begin
          push.put  = 1'b1;
          push.data = cur_byte;
          if (push_ack) begin
            pos_nxt = pos_r + 9'd1;
            lvl_nxt = lvl_r + 9'd1;
            s_nxt   = s_p1[PTR_W-1:0];
            cnt_nxt = cnt_r - 8'd1;
          end
        end else if (full1) begin
          status_nxt = ST_FULL;
          if (jumps_r == '0) resume_nxt = resume_here;
          state_nxt = S_TERM;
        end else begin
          state_nxt = S_DOT;
        end
      end
      S_DOT: begin
        // Separate labels when another one follows
        if (cur_byte != 8'h00) begin
          push.put  = 1'b1;
          push.data = DOT_CHAR;
          if (push_ack) begin
            pos_nxt   = pos_r + 9'd1;
            lvl_nxt   = lvl_r + 9'd1;
            state_nxt = S_LEN;
          end
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_PTR: begin
        // Check the pointer target and jump one level down
        if (ptr_bad) begin
          if (lvl_r == '0) begin
            status_nxt = ST_BAD_FIRST;
            state_nxt  = S_FIN;
          end else begin
            status_nxt = ST_BAD_AFTER;
            if (jumps_r == '0) resume_nxt = resume_here;
            state_nxt = S_TERM;
          end
        end else begin
          if (jumps_r == '0) resume_nxt = resume_here;
          jumps_nxt = jumps_p1;
          if (jumps_p1 == JMP_W'(DEPTH_LIMIT)) begin
            status_nxt = ST_DEPTH;
            state_nxt  = S_FIN;
          end else begin
            s_nxt     = ptr_off[PTR_W-1:0];
            lvl_nxt   = '0;
            state_nxt = S_LEN;
          end
        end
      end
      S_TERM: begin
        push.put  = 1'b1;
        push.data = 8'h00;
        if (push_ack) begin
          pos_nxt   = pos_r + 9'd1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        push.fin = 1'b1;
        if (push_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      s_r      <= '0;
      pos_r    <= '0;
      lvl_r    <= '0;
      jumps_r  <= '0;
      resume_r <= '0;
      status_r <= ST_END;
    end else begin
      state_r  <= state_nxt;
      s_r      <= s_nxt;
      pos_r    <= pos_nxt;
      lvl_r    <= lvl_nxt;
      jumps_r  <= jumps_nxt;
      resume_r <= resume_nxt;
      status_r <= status_nxt;
    end
  end

  // Per-decode operands
  always_ff @(posedge clk) begin
    room_r  <= room_nxt;
    limit_r <= limit_nxt;
    cnt_r   <= cnt_nxt;
    hi_r    <= hi_nxt;
  end

  dnd_chunker u_chunker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (push),
    .ack        (push_ack),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // The name never outgrows the clamped space
  a_pos_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (pos_r <= room_r))
    else $error("name position beyond name space");

  // Jumps stop one short of the depth limit while walking
  a_jump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LEN) || (state_r == S_LAB) || (state_r == S_DOT) || (state_r == S_PTR))
    |-> (jumps_r < JMP_W'(DEPTH_LIMIT)))
    else $error("jump count at or past the depth limit");

  // A decode transfer starts the walk at a length byte
  a_decode_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == FUNC_DECODE)) |=> (state_r == S_LEN))
    else $error("decode did not start the walk");

  // The walk only returns to idle after closing the decode with an accepted last chunk
  a_close_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && push_ack) |=> (out_tvalid && out_tlast && (state_r == S_IDLE)))
    else $error("decode closed without a last chunk");
`endif

endmodule

@@ verif/tb_dns_name_decompressor.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for dns_name_decompressor; depends on dnd_pkg and the RTL. Loads
// packet bytes, decodes names and checks each chunk against an in-bench walker or typed row.
module tb_dns_name_decompressor;
  import dnd_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int N_PHASES     = 5;

  // One output chunk, field by field
  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  nbytes;
    logic        last;
    logic [2:0]  status;
    logic [8:0]  name_len;
    logic [9:0]  next_off;
  } chunk_t;

  // One input transfer; typed rows carry their single expected chunk
  typedef struct packed {
    logic       func;
    logic [8:0] addr;
    logic [7:0] val;
    logic [9:0] plen;
    logic [8:0] start;
    logic       typed;
    chunk_t     res;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [8:0]             cfg_data;

  // Walker state: packet copy and name space register
  logic [7:0]  pkt_bytes [0:PKT_MAX-1];
  logic [7:0]  name_bytes [0:NAME_MAX-1];
  logic [8:0]  ns_reg;
  chunk_t      name_chunks_q [$];
  stim_row_t   dir_tab [$];
  int unsigned name_starts [$];
  logic [7:0]  image [0:PKT_MAX-1];
  int          err_cnt;
  bit          tx_steady;
  bit          rx_steady;

  dns_name_decompressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Sender gap: mostly none, a few long
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stall: mostly short, a few long
  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Length byte for a generated label, now and then one of the wide 0x40..0xbf values
  function automatic int unsigned label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, 20);
    if (r < 97) return $urandom_range(30, 44);
    return $urandom_range(8'h40, 8'hbf);
  endfunction

  function automatic logic [7:0] rd_byte(int unsigned a, int unsigned lim);
    if (a >= lim || a >= PKT_MAX) return 8'h00;
    return pkt_bytes[a];
  endfunction

  function automatic string chunk_str(chunk_t x);
    return $sformatf("chars=%016h bytes=%0d last=%0d status=%0d len=%0d next=%0d",
                     x.chars, x.nbytes, x.last, x.status, x.name_len, x.next_off);
  endfunction

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic stim_row_t mk_load(int unsigned a, int unsigned v);
    stim_row_t r;
    r       = '0;
    r.func  = FUNC_LOAD;
    r.addr  = a;
    r.val   = v;
    r.plen  = $urandom_range(0, PKT_MAX);
    r.start = $urandom;
    return r;
  endfunction

  function automatic stim_row_t mk_decode(int unsigned pl, int unsigned st);
    stim_row_t r;
    r       = '0;
    r.func  = FUNC_DECODE;
    r.addr  = $urandom;
    r.val   = $urandom;
    r.plen  = pl;
    r.start = st;
    return r;
  endfunction

  // Decode whose single chunk holds no name bytes other than zeros
  function automatic stim_row_t mk_typed(int unsigned pl, int unsigned st, int unsigned nb,
                                         logic [2:0] status, int unsigned len,
                                         int unsigned nxt);
    stim_row_t r;
    r              = mk_decode(pl, st);
    r.typed        = 1'b1;
    r.res.chars    = '0;
    r.res.nbytes   = nb;
    r.res.last     = 1'b1;
    r.res.status   = status;
    r.res.name_len = len;
    r.res.next_off = nxt;
    return r;
  endfunction

  // Walk the name from start and queue the chunks it yields. Pointer levels are
  // flattened: a nested level only adds its bytes, so one loop with a level base suffices.
  task automatic predict_name(input logic [9:0] plen, input logic [8:0] start);
    int unsigned room, pos, lbase, s, c, off, lvl, resume, n, nxt, k, i, cnt, nch, lim;
    bit          done, term, top;
    logic [2:0]  st;
    chunk_t      e;
    room = ns_reg;
    if (room < ROOM_MIN) room = ROOM_MIN;
    if (room > NAME_MAX) room = NAME_MAX;
    lim = plen;
    for (i = 0; i < NAME_MAX; i++) name_bytes[i] = 8'h00;
    s = start;
    resume = start;
    pos = 0;
    lbase = 0;
    lvl = DEPTH_LIMIT;
    top = 1'b1;
    done = 1'b0;
    term = 1'b0;
    st = ST_END;
    while (!done) begin
      if (rd_byte(s, lim) == 0) begin
        st = ST_END;
        term = 1'b1;
      end else if (pos + 2 >= room) begin
        st = ST_FULL;
        term = 1'b1;
      end else begin
        c = rd_byte(s, lim);
        s++;
        if ((c >> 6) == PTR_TAG) begin
          off = ((c & 'h3f) << 8) | rd_byte(s, lim);
          if (off > lim) begin
            // bad pointer: nothing at all from this level if it came first
            if (pos == lbase) begin
              st = ST_BAD_FIRST;
              done = 1'b1;
            end else begin
              st = ST_BAD_AFTER;
              term = 1'b1;
            end
          end else begin
            if (top) resume = s + 1;
            top = 1'b0;
            s = off;
            lbase = pos;
            lvl--;
            if (lvl == 0) begin
              st = ST_DEPTH;
              done = 1'b1;
            end
          end
        end else begin
          while (c != 0 && pos + 1 < room) begin
            name_bytes[pos % NAME_MAX] = rd_byte(s, lim);
            s++;
            pos++;
            c--;
          end
          if (pos + 1 >= room) begin
            st = ST_FULL;
            term = 1'b1;
          end else if (rd_byte(s, lim) != 0) begin
            name_bytes[pos % NAME_MAX] = DOT_CHAR;
            pos++;
          end
        end
      end
      if (term) begin
        name_bytes[pos % NAME_MAX] = 8'h00;
        pos++;
        if (top) resume = s + 1;
        done = 1'b1;
      end
    end
    n = (pos > NAME_MAX) ? NAME_MAX : pos;
    nxt = (resume > OFFSET_SAT) ? OFFSET_SAT : resume;
    nch = (n + CHUNK_BYTES - 1) / CHUNK_BYTES;
    if (nch == 0) nch = 1;
    // Split into chunks of eight; only the last one carries the summary
    for (k = 0; k < nch; k++) begin
      cnt = (n > k * CHUNK_BYTES) ? n - k * CHUNK_BYTES : 0;
      if (cnt > CHUNK_BYTES) cnt = CHUNK_BYTES;
      e = '0;
      for (i = 0; i < cnt; i++) e.chars[8*i +: 8] = name_bytes[(k * CHUNK_BYTES + i) % NAME_MAX];
      e.nbytes = cnt;
      e.last = (k + 1 == nch);
      if (e.last) begin
        e.status = st;
        e.name_len = n;
        e.next_off = nxt;
      end
      name_chunks_q.push_back(e);
    end
  endtask

  // Present one item at the falling edge and hold it until the transfer
  task automatic push_item(input stim_row_t row);
    int g;
    g = tx_steady ? 0 : gap_cycles();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.func;
    in_tdata  <= {4'b0, row.start, row.plen, row.val, row.addr};
    do @(posedge clk); while (!in_tready);
    if (row.func == FUNC_LOAD) pkt_bytes[row.addr] = row.val;
    else if (row.typed) name_chunks_q.push_back(row.res);
    else predict_name(row.plen, row.start);
    @(negedge clk);
  endtask

  // Stop sending and wait for the block to drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (name_chunks_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [8:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    ns_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build a small packet of names, load it, then decode names from it and from earlier ones
  task automatic run_phase(input int unsigned p);
    logic [7:0]  pkt [$];
    int unsigned here [$];
    int unsigned base, cap, nn, nl, lb, nb, tgt, r, i, j, k, nd, pl, st;
    base = 110 + p * 76;
    cap = ($urandom_range(0, 4) == 0) ? 48 : 16;
    nn = $urandom_range(2, 4);
    for (i = 0; i < nn && pkt.size() + 3 <= cap; i++) begin
      here.push_back(base + pkt.size());
      nl = $urandom_range(0, 3);
      for (j = 0; j < nl; j++) begin
        lb = label_len();
        nb = (lb > 63) ? $urandom_range(0, 4) : lb;
        if (pkt.size() + nb + 3 > cap) break;
        pkt.push_back(lb);
        repeat (nb) pkt.push_back($urandom_range(0, 255));
      end
      // close the name: mostly zero or a pointer back, now and then a broken pointer
      r = $urandom_range(0, 9);
      if (r < 4) tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
      else if (r == 4) tgt = $urandom_range(PKT_MAX + 1, 16383);
      else tgt = here[here.size() - 1];
      if (r <= 5) begin
        pkt.push_back(8'hc0 | ((tgt >> 8) & 'h3f));
        pkt.push_back(tgt & 'hff);
      end else begin
        pkt.push_back(8'h00);
      end
    end
    foreach (here[k]) name_starts.push_back(here[k]);
    foreach (pkt[k]) push_item(mk_load(base + k, pkt[k]));
    // corrupt one byte now and then
    if ($urandom_range(0, 3) == 0)
      push_item(mk_load(base + $urandom_range(0, pkt.size() - 1), $urandom_range(0, 255)));
    nd = $urandom_range(3, 5);
    for (k = 0; k < nd; k++) begin
      r = $urandom_range(0, 9);
      if (r < 5) st = here[$urandom_range(0, here.size() - 1)];
      else if (r < 8) st = name_starts[$urandom_range(0, name_starts.size() - 1)];
      else st = $urandom_range(0, PKT_MAX - 1);
      r = $urandom_range(0, 9);
      if (r < 6) pl = PKT_MAX;
      else if (r < 9) pl = base + pkt.size();
      else pl = $urandom_range(0, PKT_MAX);
      push_item(mk_decode(pl, st));
    end
  endtask

  // Receiver: random stalls unless held steady
  initial begin
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 5) == 0) stall = stall_len();
      end
    end
  end

  // Check each chunk transfer against the oldest expected chunk
  always @(posedge clk) begin : chunk_check
    chunk_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.chars    = out_tdata[63:0];
      got.nbytes   = out_tdata[67:64];
      got.status   = out_tdata[70:68];
      got.name_len = out_tdata[79:71];
      got.next_off = out_tdata[89:80];
      got.last     = out_tlast;
      if (name_chunks_q.size() == 0) begin
        flag_error($sformatf("unexpected chunk %s", chunk_str(got)));
      end else begin
        want = name_chunks_q.pop_front();
        if (got.chars !== want.chars || got.nbytes !== want.nbytes ||
            got.last !== want.last || got.status !== want.status ||
            got.name_len !== want.name_len || got.next_off !== want.next_off)
          flag_error($sformatf("chunk mismatch\n  exp %s\n  got %s",
                               chunk_str(want), chunk_str(got)));
      end
    end
  end

  initial begin
    int unsigned a, p;
    logic [8:0]  ns_plan [N_PHASES];
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    err_cnt   = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    ns_reg    = 9'd256;

    // Packet image: hand-made names at the bottom, random bytes elsewhere
    for (a = 0; a < PKT_MAX; a++) image[a] = $urandom_range(0, 255);
    image[0]  = 8'd3;  image[1]  = "w";   image[2]  = "w";   image[3]  = "w";
    image[4]  = 8'd2;  image[5]  = "a";   image[6]  = "b";   image[7]  = 8'h00;
    image[8]  = 8'hff; image[9]  = 8'hff; image[10] = 8'hc0; image[11] = 8'd16;
    image[12] = 8'hc0; image[13] = 8'h00; image[14] = 8'd1;  image[15] = "x";
    image[16] = 8'hc0; image[17] = 8'h00; image[18] = 8'd1;  image[19] = "y";
    image[20] = 8'hc1; image[21] = 8'hff; image[22] = 8'hc0; image[23] = 8'd22;
    image[24] = 8'h41;
    image[300] = 8'hbf;
    image[492] = 8'h50;
    name_starts = '{0, 12, 14, 18};

    // Directed rows
    dir_tab.push_back(mk_typed(16, 7, 1, ST_END, 1, 8));          // zero label at once
    dir_tab.push_back(mk_typed(0, 511, 1, ST_END, 1, 512));       // empty packet
    dir_tab.push_back(mk_decode(16, 0));                          // plain name
    dir_tab.push_back(mk_typed(16, 8, 0, ST_BAD_FIRST, 0, 8));    // bad pointer first
    dir_tab.push_back(mk_typed(16, 10, 1, ST_END, 1, 12));        // pointer at packet end
    dir_tab.push_back(mk_decode(32, 12));                         // pointer only
    dir_tab.push_back(mk_decode(32, 14));                         // label then pointer
    dir_tab.push_back(mk_decode(32, 18));                         // bad pointer after data
    dir_tab.push_back(mk_typed(32, 22, 0, ST_DEPTH, 0, 24));      // pointer loop
    dir_tab.push_back(mk_load(511, 8'hff));
    dir_tab.push_back(mk_typed(512, 511, 0, ST_BAD_FIRST, 0, 511));
    dir_tab.push_back(mk_decode(512, 24));                        // wide length byte
    dir_tab.push_back(mk_decode(512, 300));                       // fills the name space
    dir_tab.push_back(mk_load(0, 8'h00));
    dir_tab.push_back(mk_typed(512, 0, 1, ST_END, 1, 1));
    dir_tab.push_back(mk_decode(512, 12));
    dir_tab.push_back(mk_load(0, 8'h03));
    dir_tab.push_back(mk_decode(7, 0));                           // length cuts the name
    dir_tab.push_back(mk_decode(1, 0));                           // label reads past packet

    ns_plan[0] = 9'd0;
    ns_plan[1] = 9'd256;
    ns_plan[2] = 9'd3;
    ns_plan[3] = 9'd511;
    ns_plan[4] = $urandom_range(4, 255);

    // Reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the whole packet memory so no read ever hits an unwritten byte
    for (a = 0; a < PKT_MAX; a++) push_item(mk_load(a, image[a]));
    foreach (dir_tab[a]) push_item(dir_tab[a]);

    // Random phases, each at its own name space
    for (p = 0; p < N_PHASES; p++) begin
      wait_idle();
      cfg_write(ns_plan[p]);
      tx_steady = (p == 2);
      rx_steady = (p == 2);
      run_phase(p);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && name_chunks_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dnd_pkg.sv
rtl/dnd_ram.sv
rtl/dnd_chunker.sv
rtl/dns_name_decompressor.sv
verif/tb_dns_name_decompressor.sv
